FILE: hw/rtl/rlmc_pkg.sv
package rlmc_pkg;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_IDLE    = 3'd1,
    MODE_RX_IDLE = 3'd2,
    MODE_RX_BUSY = 3'd3,
    MODE_TX_IDLE = 3'd4,
    MODE_TX_BUSY = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_IDLE = 2'd1,
    CMD_RX   = 2'd2,
    CMD_TX   = 2'd3
  } cmd_t;

  localparam logic [1:0] FUNC_POLL  = 2'd0;
  localparam logic [1:0] FUNC_EVENT = 2'd1;
  localparam logic [1:0] FUNC_RESET = 2'd2;

  localparam logic [2:0] CAUSE_RX_START = 3'd0;
  localparam logic [2:0] CAUSE_RX_OK    = 3'd1;
  localparam logic [2:0] CAUSE_TX_OK    = 3'd2;
  localparam logic [2:0] CAUSE_TX_FAIL  = 3'd3;
  localparam logic [2:0] CAUSE_HW_FAIL  = 3'd4;

  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_WD_ENABLE   = 2'd1;
  localparam logic [1:0] CFG_WD_TIMEOUT  = 2'd2;

  localparam logic [7:0]  RESET_RETRY_LIMIT = 8'd2;
  localparam logic [15:0] RESET_WD_TIMEOUT  = 16'd400;

  typedef struct packed {
    logic [7:0]  retry_limit;
    logic        wd_enable;
    logic [15:0] wd_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic        tx_pending;
    logic [2:0]  event_cause;
    logic        rx_queue_full;
  } item_t;

  typedef struct packed {
    mode_t       link_mode;
    logic [7:0]  next_seq;
    logic [7:0]  retry_count;
    logic [31:0] progress_ms;
  } link_state_t;

  typedef struct packed {
    cmd_t       mode_command;
    logic       transceiver_reset;
    logic       start_transmit;
    logic [7:0] frame_sequence;
    logic       release_head;
    logic       capture_rx;
    mode_t      mode_now;
    logic [7:0] retry_now;
  } result_t;

endpackage

FILE: hw/rtl/radio_link_mode_controller.sv
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle unless out_ready stalls the output; the input
// register and the result register each advance whenever the stage behind them
// is free or being emptied. Reset (rst_n, synchronous, active low) empties both
// registers, sets the mode to idle, clears sequence, retry count and progress
// time, and loads the register defaults.
module radio_link_mode_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_now_ms,
  input  logic        in_tx_pending,
  input  logic [2:0]  in_event_cause,
  input  logic        in_rx_queue_full,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_mode_command,
  output logic        out_transceiver_reset,
  output logic        out_start_transmit,
  output logic [7:0]  out_frame_sequence,
  output logic        out_release_head,
  output logic        out_capture_rx,
  output logic [2:0]  out_mode_now,
  output logic [7:0]  out_retry_now,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  rlmc_pkg::cfg_t        cfg;
  rlmc_pkg::item_t       item_r;
  rlmc_pkg::link_state_t state_r;
  rlmc_pkg::link_state_t state_nxt;
  rlmc_pkg::result_t     res_nxt;
  rlmc_pkg::result_t     res_r;
  logic                  item_valid_r;
  logic                  out_valid_r;
  logic                  advance;

  rlmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rlmc_step u_step (
    .cfg    (cfg),
    .item   (item_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.func          <= in_func;
      item_r.now_ms        <= in_now_ms;
      item_r.tx_pending    <= in_tx_pending;
      item_r.event_cause   <= in_event_cause;
      item_r.rx_queue_full <= in_rx_queue_full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.link_mode   <= rlmc_pkg::MODE_IDLE;
      state_r.next_seq    <= 8'd0;
      state_r.retry_count <= 8'd0;
      state_r.progress_ms <= 32'd0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_mode_command      = res_r.mode_command;
  assign out_transceiver_reset = res_r.transceiver_reset;
  assign out_start_transmit    = res_r.start_transmit;
  assign out_frame_sequence    = res_r.frame_sequence;
  assign out_release_head      = res_r.release_head;
  assign out_capture_rx        = res_r.capture_rx;
  assign out_mode_now          = res_r.mode_now;
  assign out_retry_now         = res_r.retry_now;

endmodule

FILE: hw/rtl/rlmc_cfg_regs.sv
module rlmc_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output rlmc_pkg::cfg_t     cfg
);

  rlmc_pkg::cfg_t cfg_r;
  rlmc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        rlmc_pkg::CFG_RETRY_LIMIT: cfg_nxt.retry_limit = cfg_wdata[7:0];
        rlmc_pkg::CFG_WD_ENABLE:   cfg_nxt.wd_enable   = cfg_wdata[0];
        rlmc_pkg::CFG_WD_TIMEOUT:  cfg_nxt.wd_timeout  = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit <= rlmc_pkg::RESET_RETRY_LIMIT;
      cfg_r.wd_enable   <= 1'b1;
      cfg_r.wd_timeout  <= rlmc_pkg::RESET_WD_TIMEOUT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/rlmc_step.sv
module rlmc_step (
  input  rlmc_pkg::cfg_t        cfg,
  input  rlmc_pkg::item_t       item,
  input  rlmc_pkg::link_state_t st,
  output rlmc_pkg::link_state_t st_nxt,
  output rlmc_pkg::result_t     res
);

  logic [31:0] elapsed;
  logic        wd_trip;
  logic        busy;
  logic [8:0]  retry_inc;

  assign elapsed   = item.now_ms - st.progress_ms;
  assign wd_trip   = cfg.wd_enable && (elapsed > {16'd0, cfg.wd_timeout});
  assign busy      = (st.link_mode == rlmc_pkg::MODE_RX_BUSY) ||
                     (st.link_mode == rlmc_pkg::MODE_TX_BUSY);
  assign retry_inc = {1'b0, st.retry_count} + 9'd1;

  always_comb begin
    st_nxt                = st;
    res.mode_command      = rlmc_pkg::CMD_NONE;
    res.transceiver_reset = 1'b0;
    res.start_transmit    = 1'b0;
    res.frame_sequence    = 8'd0;
    res.release_head      = 1'b0;
    res.capture_rx        = 1'b0;

    case (item.func)
      rlmc_pkg::FUNC_RESET: begin
        res.transceiver_reset = 1'b1;
        res.mode_command      = rlmc_pkg::CMD_IDLE;
        st_nxt.link_mode      = rlmc_pkg::MODE_IDLE;
        st_nxt.progress_ms    = item.now_ms;
      end
      rlmc_pkg::FUNC_POLL: begin
        if (wd_trip) begin
          res.transceiver_reset = 1'b1;
          res.mode_command      = rlmc_pkg::CMD_IDLE;
          st_nxt.link_mode      = rlmc_pkg::MODE_IDLE;
          st_nxt.progress_ms    = item.now_ms;
        end else if (item.tx_pending) begin
          if (st.link_mode == rlmc_pkg::MODE_TX_IDLE || !busy) begin
            if (st.link_mode != rlmc_pkg::MODE_TX_IDLE) begin
              res.mode_command = rlmc_pkg::CMD_TX;
            end
            st_nxt.progress_ms = item.now_ms;
            st_nxt.link_mode   = rlmc_pkg::MODE_TX_BUSY;
            res.start_transmit = 1'b1;
            res.frame_sequence = st.next_seq;
            st_nxt.next_seq    = st.next_seq + 8'd1;
          end
        end else begin
          if (st.link_mode == rlmc_pkg::MODE_RX_IDLE || !busy) begin
            if (st.link_mode != rlmc_pkg::MODE_RX_IDLE) begin
              res.mode_command = rlmc_pkg::CMD_RX;
              st_nxt.link_mode = rlmc_pkg::MODE_RX_IDLE;
            end
            st_nxt.progress_ms = item.now_ms;
          end
        end
      end
      rlmc_pkg::FUNC_EVENT: begin
        case (st.link_mode)
          rlmc_pkg::MODE_RX_IDLE: begin
            if (item.event_cause == rlmc_pkg::CAUSE_RX_START) begin
              st_nxt.link_mode = rlmc_pkg::MODE_RX_BUSY;
            end
          end
          rlmc_pkg::MODE_RX_BUSY: begin
            if (item.event_cause == rlmc_pkg::CAUSE_RX_OK) begin
              res.capture_rx   = !item.rx_queue_full;
              st_nxt.link_mode = rlmc_pkg::MODE_RX_IDLE;
            end
          end
          rlmc_pkg::MODE_TX_BUSY: begin
            st_nxt.link_mode = rlmc_pkg::MODE_TX_IDLE;
            if (item.event_cause == rlmc_pkg::CAUSE_TX_OK) begin
              res.release_head = 1'b1;
              res.mode_command = rlmc_pkg::CMD_RX;
              st_nxt.link_mode = rlmc_pkg::MODE_RX_IDLE;
            end else if (item.event_cause == rlmc_pkg::CAUSE_TX_FAIL) begin
              if (retry_inc > {1'b0, cfg.retry_limit}) begin
                st_nxt.retry_count = 8'd0;
                res.release_head   = 1'b1;
                res.mode_command   = rlmc_pkg::CMD_RX;
                st_nxt.link_mode   = rlmc_pkg::MODE_RX_IDLE;
              end else begin
                st_nxt.retry_count = retry_inc[7:0];
              end
            end
          end
          default: begin
            st_nxt.link_mode = st.link_mode;
          end
        endcase
        if (item.event_cause == rlmc_pkg::CAUSE_HW_FAIL) begin
          res.transceiver_reset = 1'b1;
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase

    res.mode_now  = st_nxt.link_mode;
    res.retry_now = st_nxt.retry_count;
  end

endmodule
